// ===== design/bfsa_pkg.sv =====
// Package for the bitmap free space allocator.
// Holds sizes, the mode codes and the controller/datapath command and status structs.
// No dependencies.
package bfsa_pkg;

    localparam int NUM_ENTRIES = 128;
    localparam int MAX_REQUEST = 64;

    // field widths fixed by the interface
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 7;
    localparam int FREE_W  = 8;

    // bitmap organization for the scan
    localparam int WORD_W      = 16;
    localparam int NUM_WORDS   = (NUM_ENTRIES + WORD_W - 1) / WORD_W;
    localparam int BIT_IDX_W   = $clog2(WORD_W);
    localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int MAP_W       = NUM_WORDS * WORD_W;
    localparam int ENTRY_W     = $clog2(MAP_W);
    localparam int CTR_W       = $clog2(NUM_ENTRIES + 1);
    localparam int REQ_W       = $clog2(MAX_REQUEST + 1);

    typedef enum logic [1:0] {
        MODE_FIND  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef struct packed {
        logic latch;        // capture the input item
        logic emit_single;  // produce the one result of a non-scan item
        logic scan_init;    // start a scan from entry 0
        logic scan_emit;    // emit the lowest free entry of the current word
        logic scan_next;    // move to the next word
    } cmd_t;

    typedef struct packed {
        logic slot_free;    // output register can take a result this cycle
        logic is_find;
        logic refuse;       // find that cannot be served
        logic hit;          // current word still has an unreported free entry
        logic final_hit;    // one entry left to report
    } stat_t;

endpackage

// ===== design/bfsa_ctrl.sv =====
// Controller for the bitmap free space allocator.
// Sequences accept, execute and scan; depends on bfsa_pkg.
module bfsa_ctrl
    import bfsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_find && !stat.refuse)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else if (stat.slot_free)
                begin
                    cmd.emit_single = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (stat.hit)
                begin
                    if (stat.slot_free)
                    begin
                        cmd.scan_emit = 1'b1;
                        if (stat.final_hit)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    a_scan_only_find: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> stat.is_find)
        else $error("scan running for a non-find item");

    a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> (state_reg == ST_EXEC))
        else $error("latched item not executed");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_single, cmd.scan_init, cmd.scan_emit, cmd.scan_next}))
        else $error("conflicting datapath commands");

endmodule

// ===== design/bfsa_dpath.sv =====
// Datapath for the bitmap free space allocator.
// Bitmap, free counter, word scanner and output register; depends on bfsa_pkg.
module bfsa_dpath
    import bfsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         mode,
    input  logic [INDEX_W-1:0] index,
    input  logic [COUNT_W-1:0] count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] entry_index,
    output logic               last,
    output logic               status,
    output logic               bit_value,
    output logic [FREE_W-1:0]  free_count,
    input  cmd_t               cmd,
    output stat_t              stat
);

    mode_t                 op_mode_reg;
    logic [INDEX_W-1:0]    op_index_reg;
    logic [COUNT_W-1:0]    op_count_reg;

    logic [MAP_W-1:0]      used_map_reg;
    logic [MAP_W-1:0]      used_map_next;
    logic [CTR_W-1:0]      free_counter_reg;
    logic [CTR_W-1:0]      free_counter_next;

    logic [WORD_IDX_W-1:0] word_reg;
    logic [WORD_W-1:0]     mask_reg;
    logic [REQ_W-1:0]      remain_reg;

    logic                  out_valid_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic                  out_last_reg;
    logic                  out_status_reg;
    logic                  out_bit_reg;
    logic [FREE_W-1:0]     out_free_reg;

    logic                  is_find;
    logic                  refuse;
    logic                  in_range;
    logic [ENTRY_W-1:0]    op_entry;
    logic                  cur_bit;
    logic                  new_bit;
    logic [WORD_W-1:0]     cur_word;
    logic [WORD_W-1:0]     free_bits;
    logic [BIT_IDX_W-1:0]  hit_bit;
    logic [ENTRY_W-1:0]    hit_entry;
    logic                  slot_free;

    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

    assign is_find   = (op_mode_reg == MODE_FIND);
    assign refuse    = (op_count_reg == '0)
                    || (32'(op_count_reg) > MAX_REQUEST)
                    || (32'(free_counter_reg) < 32'(op_count_reg));
    assign in_range  = (32'(op_index_reg) < NUM_ENTRIES);
    assign op_entry  = ENTRY_W'(op_index_reg);
    assign cur_bit   = used_map_reg[op_entry];

    assign cur_word  = used_map_reg[word_reg * WORD_W +: WORD_W];
    assign free_bits = ~cur_word & ~mask_reg;
    assign hit_bit   = lowest_set(free_bits);
    assign hit_entry = ENTRY_W'({word_reg, hit_bit});

    assign slot_free = !out_valid_reg || !out_stall;

    assign stat.slot_free = slot_free;
    assign stat.is_find   = is_find;
    assign stat.refuse    = refuse;
    assign stat.hit       = (free_bits != '0);
    assign stat.final_hit = (remain_reg == REQ_W'(1));

    // bitmap and counter update for set and clear
    always_comb
    begin
        used_map_next     = used_map_reg;
        free_counter_next = free_counter_reg;
        new_bit           = cur_bit;
        if (!is_find && in_range)
        begin
            case (op_mode_reg)
                MODE_SET:
                begin
                    new_bit = 1'b1;
                    if (!cur_bit && (free_counter_reg != '0))
                    begin
                        free_counter_next = free_counter_reg - CTR_W'(1);
                    end
                end
                MODE_CLEAR:
                begin
                    new_bit = 1'b0;
                    if (cur_bit)
                    begin
                        free_counter_next = free_counter_reg + CTR_W'(1);
                    end
                end
                default:
                begin
                    new_bit = cur_bit;
                end
            endcase
            used_map_next[op_entry] = new_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_map_reg     <= '0;
            free_counter_reg <= CTR_W'(NUM_ENTRIES);
        end
        else if (cmd.emit_single)
        begin
            used_map_reg     <= used_map_next;
            free_counter_reg <= free_counter_next;
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_mode_reg  <= mode_t'(mode);
            op_index_reg <= index;
            op_count_reg <= count;
        end
    end

    // scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg   <= '0;
            mask_reg   <= '0;
            remain_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            word_reg   <= '0;
            mask_reg   <= '0;
            remain_reg <= REQ_W'(op_count_reg);
        end
        else if (cmd.scan_emit)
        begin
            mask_reg[hit_bit] <= 1'b1;
            remain_reg        <= remain_reg - REQ_W'(1);
        end
        else if (cmd.scan_next)
        begin
            word_reg <= word_reg + WORD_IDX_W'(1);
            mask_reg <= '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_single || cmd.scan_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_emit)
        begin
            out_index_reg  <= INDEX_W'(hit_entry);
            out_last_reg   <= (remain_reg == REQ_W'(1));
            out_status_reg <= 1'b0;
            out_bit_reg    <= 1'b0;
            out_free_reg   <= FREE_W'(free_counter_reg);
        end
        else if (cmd.emit_single)
        begin
            out_last_reg <= 1'b1;
            out_free_reg <= FREE_W'(free_counter_next);
            if (is_find)
            begin
                out_index_reg  <= '0;
                out_status_reg <= 1'b1;
                out_bit_reg    <= 1'b0;
            end
            else
            begin
                out_index_reg  <= op_index_reg;
                out_status_reg <= 1'b0;
                out_bit_reg    <= in_range ? new_bit : 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = out_index_reg;
    assign last        = out_last_reg;
    assign status      = out_status_reg;
    assign bit_value   = out_bit_reg;
    assign free_count  = out_free_reg;

    a_emit_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_emit |-> (stat.hit && slot_free))
        else $error("scan emitted without a free entry or output slot");

    a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_counter_reg) <= NUM_ENTRIES)
        else $error("free counter above entry count");

    a_final_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_emit && stat.final_hit) |=> (out_valid_reg && out_last_reg))
        else $error("final scan result not marked last");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule

// ===== design/bitmap_free_space_allocator.sv =====
// Top level of the bitmap free space allocator: first-fit bitmap with a free counter.
// Instantiates bfsa_ctrl and bfsa_dpath; depends on bfsa_pkg.
//
//   channel  handshake            fields
//   in       in_valid / in_stall   mode, index, count
//   out      out_valid / out_stall entry_index, last, status, bit_value, free_count
//
// Set, clear, query and refused finds are accepted, then executed into the output
// register. A served find is accepted, then scanned: each result is reported and
// each 16-entry bitmap word with no unreported free entry is stepped past (at most 8 words).
// The scanner reports one free entry per cycle from the current word unless out stalls.
// Reset clears the bitmap and loads the free counter at once; no clearing pass.
// A stall on out holds the result and the scan; in is stalled until the item's
// last result is in the output register, which may still be waiting.
module bitmap_free_space_allocator
    import bfsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [INDEX_W-1:0] index,
    input  logic [COUNT_W-1:0] count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] entry_index,
    output logic               last,
    output logic               status,
    output logic               bit_value,
    output logic [FREE_W-1:0]  free_count
);

    cmd_t  cmd;
    stat_t stat;

    bfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfsa_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .index       (index),
        .count       (count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .entry_index (entry_index),
        .last        (last),
        .status      (status),
        .bit_value   (bit_value),
        .free_count  (free_count),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
